// ===== hw/rtl/bfa_pkg.sv =====
// Shared constants, status codes and sequencer states of the block list allocator.
`timescale 1ns / 1ps
package bfa_pkg;

	localparam int DEF_MAX_BLOCKS = 16;
	localparam int DEF_HEAP_BYTES = 65536;
	localparam int GRANULE        = 32;
	localparam int HEADER_BYTES   = 32;
	localparam int REQ_W          = 17;
	localparam int ADDR_W         = 16;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_EXHAUSTED    = 2'd1,
		ST_TABLE_FULL   = 2'd2,
		ST_UNKNOWN_ADDR = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SCAN = 8'b0000_0010,
		S_NEXT = 8'b0000_0100,
		S_PLAN = 8'b0000_1000,
		S_WR1  = 8'b0001_0000,
		S_MOVE = 8'b0010_0000,
		S_WR2  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} fsm_t;

endpackage

// ===== hw/rtl/bfa_table.sv =====
// Block table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module bfa_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hw/rtl/block_list_fit_allocator_top.sv =====
// Top level of the block list allocator: sequencer over the block table.
// One request at a time; in_stall is high from acceptance until its result is
// loaded. A request scans the table entries in turn, then does its bookkeeping
// and, when a block is inserted or merged away, shifts the table entries behind
// it; the finished result may also wait for the previous beat to leave. The
// single read port of the block table makes scan and shift both walk it one
// entry a cycle. fit_mode is taken from cfg_wr_data when cfg_wr_en is high.
`timescale 1ns / 1ps
module block_list_fit_allocator_top import bfa_pkg::*; #(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [REQ_W-1:0]  request_size,
	input  logic [ADDR_W-1:0] release_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] payload_address
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int HW = $clog2(HEAP_BYTES + 1);
	localparam int SW = (HW > REQ_W + 1) ? HW : REQ_W + 1;
	localparam int AW = (HW + 1 > ADDR_W) ? HW + 1 : ADDR_W;
	localparam int EW = 1 + SW + HW;
	localparam logic [SW:0]   HEAP_LIM = (SW + 1)'(HEAP_BYTES);
	localparam logic [SW-1:0] HDR      = SW'(HEADER_BYTES);
	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BLOCKS);

	typedef struct packed {
		logic          free;
		logic [SW-1:0] size;
		logic [HW-1:0] off;
	} entry_t;

	fsm_t state_q;
	logic fit_mode_q;
	logic [CW-1:0] count_q, count_n_q;
	logic [HW-1:0] heap_top_q, heap_n_q;
	logic act_q;
	logic [SW-1:0] need_q;
	logic [ADDR_W-1:0] addr_q;

	logic [CW-1:0] scan_i_q;
	logic rv_q;
	logic [IW-1:0] ri_q;
	entry_t prev_e_q;
	logic has_used_q;
	logic [CW-1:0] lu_q;
	logic found_q;
	logic [IW-1:0] pick_q;
	entry_t pick_e_q;
	logic [SW-1:0] slack_q;
	logic hit_q;
	logic [IW-1:0] hit_i_q;
	entry_t hit_e_q, hitp_e_q;

	logic wr1_en_q, wr2_en_q;
	logic [IW-1:0] wr1_addr_q, wr2_addr_q;
	entry_t wr1_e_q, wr2_e_q;
	logic mv_up_q;
	logic [1:0] mv_k_q;
	logic [CW:0] mv_src_q;
	logic [CW-1:0] mv_n_q;
	logic pend_q;
	logic [CW:0] pend_dst_q;
	logic [1:0] stat_n_q;
	logic [ADDR_W-1:0] pay_n_q;
	logic [1:0] res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic res_valid_q;

	logic [IW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] rd_data;
	logic wr_en;
	entry_t wr_e, e;

	assign e = entry_t'(rd_data);

	bfa_table #(.DEPTH(MAX_BLOCKS), .AW(IW), .DW(EW)) u_table (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (EW'(wr_e))
	);

	logic in_acc;
	logic [REQ_W:0] req_ext;
	logic [SW-1:0] e_slack;
	logic e_fits, alloc_take, rel_hit, stop, scan_end;
	logic [AW-1:0] e_pay;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = res_valid_q;
	assign status    = res_status_q;
	assign payload_address = res_addr_q;
	assign req_ext   = {1'b0, request_size} + (REQ_W + 1)'(GRANULE - 1);

	assign e_fits  = e.free && (e.size >= need_q);
	assign e_slack = e.size - need_q;
	assign e_pay   = AW'(e.off) + AW'(HEADER_BYTES);
	assign alloc_take = rv_q && !act_q && e_fits &&
		(!found_q || (fit_mode_q && (e_slack < slack_q)));
	assign rel_hit  = rv_q && act_q && !e.free && (e_pay == AW'(addr_q));
	assign stop     = (rv_q && !act_q && e_fits && !fit_mode_q) || rel_hit;
	assign scan_end = stop || (!rv_q && (scan_i_q >= count_q));

	// plan of table updates
	logic p_split, p_nf, p_pf;
	logic [SW:0] p_grow;
	logic [CW-1:0] p_pos, p_dst0;
	logic [CW:0] p_src0;
	logic [1:0] p_k;
	logic [SW-1:0] p_add_p, p_add_n;
	logic [AW-1:0] p_pick_pay, p_top_pay;
	entry_t nx;

	assign nx        = e;
	assign p_split   = (slack_q >= HDR) && (count_q < CNT_MAX);
	assign p_grow    = (SW + 1)'(heap_top_q) + (SW + 1)'(HEADER_BYTES) + {1'b0, need_q};
	assign p_pos     = has_used_q ? lu_q : count_q;
	assign p_nf      = ((CW'(hit_i_q) + CW'(1)) < count_q) && nx.free;
	assign p_pf      = (hit_i_q != '0) && hitp_e_q.free;
	assign p_k       = {1'b0, p_nf} + {1'b0, p_pf};
	assign p_dst0    = p_pf ? CW'(hit_i_q) : CW'(hit_i_q) + CW'(1);
	assign p_src0    = {1'b0, p_dst0} + (CW + 1)'(p_k);
	assign p_add_p   = p_pf ? hitp_e_q.size + HDR : '0;
	assign p_add_n   = p_nf ? nx.size + HDR : '0;
	assign p_pick_pay = AW'(pick_e_q.off) + AW'(HEADER_BYTES);
	assign p_top_pay  = AW'(heap_top_q) + AW'(HEADER_BYTES);

	always_comb begin
		rd_addr = scan_i_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = wr1_addr_q;
		wr_e    = wr1_e_q;
		unique case (state_q)
			S_NEXT: begin
				rd_addr = hit_i_q + IW'(1);
			end
			S_WR1: begin
				wr_en = wr1_en_q;
			end
			S_MOVE: begin
				rd_addr = mv_src_q[IW-1:0];
				wr_en   = pend_q;
				wr_addr = pend_dst_q[IW-1:0];
				wr_e    = e;
			end
			S_WR2: begin
				wr_en   = wr2_en_q;
				wr_addr = wr2_addr_q;
				wr_e    = wr2_e_q;
			end
			default: begin
				rd_addr = scan_i_q[IW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fit_mode_q  <= 1'b0;
			count_q     <= '0;
			heap_top_q  <= '0;
			res_valid_q <= 1'b0;
			rv_q        <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fit_mode_q <= cfg_wr_data;
			end
			if (res_valid_q && !out_stall && (state_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						act_q      <= action;
						need_q     <= SW'({req_ext[REQ_W:5], 5'b0});
						addr_q     <= release_address;
						scan_i_q   <= '0;
						rv_q       <= 1'b0;
						found_q    <= 1'b0;
						hit_q      <= 1'b0;
						has_used_q <= 1'b0;
						slack_q    <= '0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_i_q < count_q) begin
						scan_i_q <= scan_i_q + CW'(1);
						ri_q     <= scan_i_q[IW-1:0];
						rv_q     <= 1'b1;
					end else begin
						rv_q <= 1'b0;
					end
					if (rv_q) begin
						prev_e_q <= e;
						if (!e.free) begin
							has_used_q <= 1'b1;
							lu_q       <= CW'(ri_q) + CW'(1);
						end
					end
					if (alloc_take) begin
						found_q  <= 1'b1;
						pick_q   <= ri_q;
						pick_e_q <= e;
						slack_q  <= e_slack;
					end
					if (rel_hit) begin
						hit_q    <= 1'b1;
						hit_i_q  <= ri_q;
						hit_e_q  <= e;
						hitp_e_q <= prev_e_q;
					end
					if (scan_end) begin
						rv_q    <= 1'b0;
						state_q <= act_q ? S_NEXT : S_PLAN;
					end
				end
				S_NEXT: begin
					state_q <= S_PLAN;
				end
				S_PLAN: begin
					wr1_en_q     <= 1'b0;
					wr2_en_q     <= 1'b0;
					mv_n_q       <= '0;
					mv_up_q      <= 1'b1;
					mv_k_q       <= 2'd1;
					mv_src_q     <= (CW + 1)'(count_q) - (CW + 1)'(1);
					pend_q       <= 1'b0;
					count_n_q    <= count_q;
					heap_n_q     <= heap_top_q;
					stat_n_q     <= ST_OK;
					pay_n_q      <= '0;
					if (act_q) begin
						if (!hit_q) begin
							stat_n_q <= ST_UNKNOWN_ADDR;
						end else begin
							wr1_en_q      <= 1'b1;
							wr1_addr_q    <= p_pf ? hit_i_q - IW'(1) : hit_i_q;
							wr1_e_q.free  <= 1'b1;
							wr1_e_q.off   <= p_pf ? hitp_e_q.off : hit_e_q.off;
							wr1_e_q.size  <= hit_e_q.size + p_add_p + p_add_n;
							mv_up_q       <= 1'b0;
							mv_k_q        <= p_k;
							mv_src_q      <= p_src0;
							mv_n_q        <= (p_k != 2'd0 && p_src0 < (CW + 1)'(count_q)) ?
								CW'((CW + 1)'(count_q) - p_src0) : '0;
							count_n_q     <= count_q - CW'(p_k);
						end
					end else if (found_q) begin
						pay_n_q       <= p_pick_pay[ADDR_W-1:0];
						wr1_en_q      <= 1'b1;
						wr1_addr_q    <= pick_q;
						wr1_e_q.free  <= 1'b0;
						wr1_e_q.off   <= pick_e_q.off;
						wr1_e_q.size  <= p_split ? need_q : pick_e_q.size;
						if (p_split) begin
							mv_n_q        <= count_q - CW'(pick_q) - CW'(1);
							wr2_en_q      <= 1'b1;
							wr2_addr_q    <= pick_q + IW'(1);
							wr2_e_q.free  <= 1'b1;
							wr2_e_q.off   <= HW'(SW'(pick_e_q.off) + HDR + need_q);
							wr2_e_q.size  <= slack_q - HDR;
							count_n_q     <= count_q + CW'(1);
						end
					end else if (p_grow > HEAP_LIM) begin
						stat_n_q <= ST_EXHAUSTED;
					end else if (count_q >= CNT_MAX) begin
						stat_n_q <= ST_TABLE_FULL;
					end else begin
						pay_n_q       <= p_top_pay[ADDR_W-1:0];
						mv_n_q        <= count_q - p_pos;
						wr2_en_q      <= 1'b1;
						wr2_addr_q    <= p_pos[IW-1:0];
						wr2_e_q.free  <= 1'b0;
						wr2_e_q.off   <= heap_top_q;
						wr2_e_q.size  <= need_q;
						count_n_q     <= count_q + CW'(1);
						heap_n_q      <= HW'(p_grow);
					end
					state_q <= S_WR1;
				end
				S_WR1: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					if (mv_n_q != '0) begin
						mv_n_q     <= mv_n_q - CW'(1);
						pend_q     <= 1'b1;
						pend_dst_q <= mv_up_q ? mv_src_q + (CW + 1)'(1) :
							mv_src_q - (CW + 1)'(mv_k_q);
						mv_src_q   <= mv_up_q ? mv_src_q - (CW + 1)'(1) :
							mv_src_q + (CW + 1)'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_WR2;
						end
					end
				end
				S_WR2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || !out_stall) begin
						res_valid_q  <= 1'b1;
						res_status_q <= stat_n_q;
						res_addr_q   <= pay_n_q;
						count_q      <= count_n_q;
						heap_top_q   <= heap_n_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the block list allocator: directed and random alloc/release traffic.
`timescale 1ns / 1ps
module tb;
	import bfa_pkg::*;

	localparam int NBLK = DEF_MAX_BLOCKS;
	localparam int HEAP = DEF_HEAP_BYTES;

	typedef struct packed {
		status_t      st;
		logic [15:0]  addr;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [REQ_W-1:0] request_size = '0;
	logic [ADDR_W-1:0] release_address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [ADDR_W-1:0] payload_address;

	block_list_fit_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.request_size(request_size), .release_address(release_address),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.payload_address(payload_address)
	);

	always #6 clk = ~clk;

	// shadow of the block table
	logic [16:0] blk_off [NBLK];
	logic [16:0] blk_len [NBLK];
	logic        blk_free [NBLK];
	int unsigned blk_cnt;
	logic [17:0] top_ptr;
	logic        fit_sel;

	alloc_result_t pending_results [$];
	logic [15:0] live_addrs [$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_cycles = 0;
	int n_alloc_ok = 0, n_exh = 0, n_full = 0, n_unknown = 0;

	function automatic void shift_up(int unsigned pos);
		for (int unsigned i = blk_cnt; i > pos; i--) begin
			blk_off[i] = blk_off[i-1];
			blk_len[i] = blk_len[i-1];
			blk_free[i] = blk_free[i-1];
		end
		blk_cnt++;
	endfunction

	function automatic void shift_down(int unsigned pos);
		for (int unsigned i = pos; i + 1 < blk_cnt; i++) begin
			blk_off[i] = blk_off[i+1];
			blk_len[i] = blk_len[i+1];
			blk_free[i] = blk_free[i+1];
		end
		blk_cnt--;
	endfunction

	function automatic alloc_result_t model_alloc(logic [16:0] req);
		alloc_result_t r;
		logic [17:0] need;
		logic [17:0] slack, best;
		bit found;
		int unsigned pick, pos;
		need = ((18'(req) + 18'd31) >> 5) << 5;
		found = 0; pick = 0; best = 0;
		r.st = ST_OK; r.addr = '0;
		for (int unsigned i = 0; i < blk_cnt; i++) begin
			if (blk_free[i] && 18'(blk_len[i]) >= need) begin
				slack = 18'(blk_len[i]) - need;
				if (!found || (fit_sel && slack < best)) begin
					found = 1; pick = i; best = slack;
					if (!fit_sel) break;
				end
			end
		end
		if (found) begin
			blk_free[pick] = 0;
			if (best >= HEADER_BYTES && blk_cnt < NBLK) begin
				blk_len[pick] = need[16:0];
				shift_up(pick + 1);
				blk_off[pick+1] = 17'(blk_off[pick] + HEADER_BYTES + need[16:0]);
				blk_len[pick+1] = 17'(best - HEADER_BYTES);
				blk_free[pick+1] = 1;
			end
			r.addr = 16'(blk_off[pick] + HEADER_BYTES);
			return r;
		end
		if (top_ptr + HEADER_BYTES + need > HEAP) begin
			r.st = ST_EXHAUSTED; return r;
		end
		if (blk_cnt >= NBLK) begin
			r.st = ST_TABLE_FULL; return r;
		end
		pos = blk_cnt;
		for (int unsigned i = blk_cnt; i > 0; i--) begin
			if (!blk_free[i-1]) begin
				pos = i; break;
			end
		end
		shift_up(pos);
		blk_off[pos] = top_ptr[16:0];
		blk_len[pos] = need[16:0];
		blk_free[pos] = 0;
		top_ptr = 18'(top_ptr + HEADER_BYTES + need);
		r.addr = 16'(blk_off[pos] + HEADER_BYTES);
		return r;
	endfunction

	function automatic alloc_result_t model_release(logic [15:0] a);
		alloc_result_t r;
		int unsigned i;
		r.st = ST_OK; r.addr = '0;
		for (i = 0; i < blk_cnt; i++)
			if (!blk_free[i] && 17'(blk_off[i] + HEADER_BYTES) == 17'(a)) break;
		if (i >= blk_cnt) begin
			r.st = ST_UNKNOWN_ADDR; return r;
		end
		blk_free[i] = 1;
		if (i + 1 < blk_cnt && blk_free[i+1]) begin
			blk_len[i] = 17'(blk_len[i] + blk_len[i+1] + HEADER_BYTES);
			shift_down(i + 1);
		end
		if (i > 0 && blk_free[i-1]) begin
			blk_len[i-1] = 17'(blk_len[i-1] + blk_len[i] + HEADER_BYTES);
			shift_down(i);
		end
		return r;
	endfunction

	task automatic send_beat(logic act, logic [16:0] sz, logic [15:0] ra);
		alloc_result_t r;
		do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		in_valid <= 1'b1;
		action <= act;
		request_size <= sz;
		release_address <= ra;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = act ? model_release(ra) : model_alloc(sz);
		if (r.st == ST_OK && !act) begin
			live_addrs.push_back(r.addr);
			n_alloc_ok++;
		end
		if (r.st == ST_EXHAUSTED) n_exh++;
		if (r.st == ST_TABLE_FULL) n_full++;
		if (r.st == ST_UNKNOWN_ADDR) n_unknown++;
		pending_results.push_back(r);
		beats_in++;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic do_alloc(logic [16:0] sz);
		send_beat(1'b0, sz, 16'($urandom));
	endtask

	task automatic do_release_live();
		int k;
		logic [15:0] a;
		if (live_addrs.size() == 0) begin
			send_beat(1'b1, 17'($urandom), 16'($urandom));
			return;
		end
		k = $urandom_range(live_addrs.size() - 1);
		a = live_addrs[k];
		live_addrs.delete(k);
		send_beat(1'b1, 17'($urandom), a);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (60) @(negedge clk);
	endtask

	task automatic write_fit_mode(logic m);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		fit_sel = m;
	endtask

	// release everything still held so later allocations reuse the freed heap blocks
	task automatic release_all();
		while (live_addrs.size() != 0) do_release_live();
	endtask

	task automatic test_directed();
		do_alloc(17'd0);
		do_alloc(17'd1);
		do_alloc(17'd32);
		do_alloc(17'd100);
		do_alloc(17'd65536);
		do_alloc(17'h1FFFF);
		send_beat(1'b1, 17'd0, 16'd0);
		send_beat(1'b1, 17'd0, 16'hFFFF);
		send_beat(1'b1, 17'd0, live_addrs[1]);
		send_beat(1'b1, 17'd0, live_addrs[1]);
		send_beat(1'b1, 17'd0, live_addrs[2]);
		live_addrs.delete(2);
		live_addrs.delete(1);
		do_alloc(17'd32);
		do_alloc(17'd64);
		send_beat(1'b1, 17'd0, live_addrs[0]);
		live_addrs.delete(0);
		do_alloc(17'd0);
		release_all();
		for (int i = 0; i < 18; i++) do_alloc(17'd64);
		do_alloc(17'd64);
		release_all();
	endtask

	task automatic test_fit_modes();
		for (int m = 1; m >= 0; m--) begin
			write_fit_mode(m[0]);
			do_alloc(17'd256);
			do_alloc(17'd32);
			do_alloc(17'd96);
			do_alloc(17'd32);
			send_beat(1'b1, 17'd0, live_addrs[0]);
			send_beat(1'b1, 17'd0, live_addrs[2]);
			live_addrs.delete(2);
			live_addrs.delete(0);
			do_alloc(17'd64);
			do_alloc(17'd0);
			release_all();
		end
	endtask

	task automatic random_phase(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 5) send_beat(1'b1, 17'($urandom), 16'($urandom));
			else if (r < 50 && live_addrs.size() > 0) do_release_live();
			else if (r < 90) do_alloc(17'($urandom_range(600)));
			else if (r < 97) do_alloc(17'($urandom_range(8192)));
			else do_alloc(17'($urandom));
		end
	endtask

	task automatic test_random();
		send_idle_pct = 26; recv_idle_pct = 46;
		write_fit_mode(1'b0);
		random_phase(260);
		send_idle_pct = 46; recv_idle_pct = 26;
		write_fit_mode(1'b1);
		random_phase(260);
		send_idle_pct = 0; recv_idle_pct = 0;
		write_fit_mode(1'b0);
		random_phase(260);
	endtask

	task automatic test_backpressure();
		hold_req++;
		for (int i = 0; i < 6; i++) do_alloc(17'($urandom_range(200)));
		release_all();
	endtask

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cycles <= 300;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: status %0d address %0h", status, payload_address);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					errors++;
				end
				if (payload_address !== e.addr) begin
					$error("payload_address: expected %0h, got %0h", e.addr, payload_address);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NBLK; i++) begin
			blk_off[i] = '0; blk_len[i] = '0; blk_free[i] = 0;
		end
		blk_cnt = 0; top_ptr = '0; fit_sel = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_fit_modes();
		test_backpressure();
		test_random();
		drain();
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("Sent %0d requests, checked %0d results across both fit modes.",
			beats_in, beats_out);
		$display("Allocs ok %0d, exhausted %0d, table full %0d, unknown address %0d.",
			n_alloc_ok, n_exh, n_full, n_unknown);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
